[rtl/core/vector_rotation_2d_top_macros.svh]
// Assertion macros used by the checker file.
`ifndef VECTOR_ROTATION_2D_TOP_MACROS_SVH
`define VECTOR_ROTATION_2D_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VR2D_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VR2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/vr2d_pkg.sv]
package vr2d_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;
  localparam int GUARD_BITS   = 8;
  localparam int ITERATIONS   = 16;
  localparam int ATAN_ENTRIES = 24;

  // Coordinates with guard bits plus headroom for the pre-rotation sign flip
  // and the rotation gain.
  localparam int WORK_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
  // Residual angle, pi equals 2^31.
  localparam int Z_WIDTH    = 32;

  localparam int GAIN_Q     = 20;
  localparam int GAIN_K     = 636751;
  localparam int GAIN_WIDTH = 21;
  localparam int PROD_WIDTH = WORK_WIDTH + GAIN_WIDTH;
  localparam int SHIFT_OUT  = GAIN_Q + GUARD_BITS;
  localparam int ROUND_WIDTH = PROD_WIDTH - SHIFT_OUT;

  localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;

  // Pre-rotation, one stage per iteration, multiply, output.
  localparam int STAGES = ITERATIONS + 3;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quadrant_t;

  typedef logic signed [WORK_WIDTH-1:0] work_t;
  typedef logic signed [Z_WIDTH-1:0]    angle_res_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;

  localparam logic [Z_WIDTH-1:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

[rtl/core/vector_rotation_2d_top.sv]
// Channel   Dir  tdata fields (lowest bit up)             Notes
// s_axis    in   x_in[15:0], y_in[31:16], angle[47:32]    one point and angle per beat
// m_axis    out  x_out[15:0], y_out[31:16]                one rotated point per beat
//
// One beat can enter every cycle when the output side does not stall.
// The pipeline has one stage per CORDIC micro-rotation plus the quadrant stage,
// the gain multiply and the round/saturate stage; each stage has its own valid bit.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// close up under a stall. Reset clears the valid bits only; the data registers are not reset.
module vector_rotation_2d_top
  import vr2d_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,  // x_in, y_in, angle
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata   // x_out, y_out
);

  localparam int MUL_STAGE = ITERATIONS + 1;
  localparam int OUT_STAGE = ITERATIONS + 2;

  localparam logic signed [GAIN_WIDTH-1:0]  GAIN    = GAIN_WIDTH'(GAIN_K);
  localparam prod_t                         ROUNDER = PROD_WIDTH'(64'sd1 <<< (SHIFT_OUT - 1));
  localparam logic signed [ROUND_WIDTH-1:0] SAT_HI  =
    ROUND_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ROUND_WIDTH-1:0] SAT_LO  = -SAT_HI - ROUND_WIDTH'(1);

  logic [STAGES-1:0] valid;
  logic [STAGES-1:0] advance;

  work_t      xs [0:ITERATIONS];
  work_t      ys [0:ITERATIONS];
  angle_res_t zs [0:ITERATIONS];

  prod_t px;
  prod_t py;

  logic signed [COORD_WIDTH-1:0] x_res;
  logic signed [COORD_WIDTH-1:0] y_res;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    advance[STAGES-1] = !valid[STAGES-1] || m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      advance[k] = !valid[k] || advance[k+1];
    end
  end

  assign s_axis_tready = advance[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (advance[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (advance[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Quadrant pre-rotation: exact swaps and negations by multiples of 90 degrees.
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic [ANGLE_WIDTH-1:0]        angle;
  logic [ANGLE_WIDTH-1:0]        angle_off;
  quadrant_t                     quad;
  logic signed [13:0]            residual;
  work_t                         x_ext;
  work_t                         y_ext;
  work_t                         x_pre;
  work_t                         y_pre;
  angle_res_t                    z_pre;

  always_comb begin
    x_in      = s_axis_tdata[COORD_WIDTH-1:0];
    y_in      = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    angle     = s_axis_tdata[2*COORD_WIDTH+ANGLE_WIDTH-1:2*COORD_WIDTH];
    angle_off = angle + ANGLE_WIDTH'(8192);
    quad      = quadrant_t'(angle_off[15:14]);
    // Residual angle minus one eighth turn: flipping the top bit subtracts 8192.
    residual  = {~angle_off[13], angle_off[12:0]};
    z_pre     = {{2{residual[13]}}, residual, 16'b0};
    x_ext     = WORK_WIDTH'(x_in);
    y_ext     = WORK_WIDTH'(y_in);
    unique case (quad)
      QUAD_0: begin
        x_pre = x_ext;
        y_pre = y_ext;
      end
      QUAD_90: begin
        x_pre = -y_ext;
        y_pre = x_ext;
      end
      QUAD_180: begin
        x_pre = -x_ext;
        y_pre = -y_ext;
      end
      QUAD_270: begin
        x_pre = y_ext;
        y_pre = -x_ext;
      end
      default: begin
        x_pre = x_ext;
        y_pre = y_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance[0] && s_axis_tvalid) begin
      xs[0] <= x_pre <<< GUARD_BITS;
      ys[0] <= y_pre <<< GUARD_BITS;
      zs[0] <= z_pre;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    localparam angle_res_t ATAN_I = angle_res_t'(ATAN_TABLE[i]);
    work_t dx;
    work_t dy;

    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;

    always_ff @(posedge clk) begin
      if (advance[i+1] && valid[i]) begin
        if (!zs[i][Z_WIDTH-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ATAN_I;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ATAN_I;
        end
      end
    end
  end

  // Gain compensation.
  always_ff @(posedge clk) begin
    if (advance[MUL_STAGE] && valid[MUL_STAGE-1]) begin
      px <= PROD_WIDTH'(xs[ITERATIONS]) * PROD_WIDTH'(GAIN);
      py <= PROD_WIDTH'(ys[ITERATIONS]) * PROD_WIDTH'(GAIN);
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] round_sat(input prod_t p);
    prod_t                         sum;
    logic signed [ROUND_WIDTH-1:0] r;
    logic signed [COORD_WIDTH-1:0] res;
    sum = p + ROUNDER;
    r   = sum[PROD_WIDTH-1:SHIFT_OUT];
    if (r > SAT_HI) begin
      res = SAT_HI[COORD_WIDTH-1:0];
    end else if (r < SAT_LO) begin
      res = SAT_LO[COORD_WIDTH-1:0];
    end else begin
      res = r[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (advance[OUT_STAGE] && valid[OUT_STAGE-1]) begin
      x_res <= round_sat(px);
      y_res <= round_sat(py);
    end
  end

  assign m_axis_tvalid = valid[OUT_STAGE];
  assign m_axis_tdata  = OUT_DATA_WIDTH'({y_res, x_res});

endmodule

[rtl/core/vr2d_checker.sv]
`include "vector_rotation_2d_top_macros.svh"

module vr2d_checker
  import vr2d_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,   // x_in, y_in, angle
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_DATA_WIDTH-1:0] m_axis_tdata    // x_out, y_out
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

  // The output is empty right after reset.
  `VR2D_ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid)
  // A result that is not taken stays and holds its data.
  `VR2D_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // With the output taking beats, the whole pipeline moves and input can be taken.
  `VR2D_ASSERT_IMPLY(a_ready_flow, clk, rst, m_axis_tready, s_axis_tready)
  // With the output stage empty, there is always room for a new beat.
  `VR2D_ASSERT_IMPLY(a_ready_empty, clk, rst, !m_axis_tvalid || in_beat, s_axis_tready)

endmodule

bind vector_rotation_2d_top vr2d_checker u_vr2d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/vector_rotation_2d_top_tb.sv]
module vector_rotation_2d_top_tb;
  import vr2d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MICRO_STEPS    = (ITERATIONS < 24) ? ITERATIONS : 24;
  localparam longint SCALE_K    = 636751;  // 1/gain in Q20
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_ITEMS     = 60;
  localparam int RANDOM_ITEMS   = 530;

  // atan(2^-i) with pi = 2^31
  localparam logic [31:0] TURN_ARC [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] angle;
    bit          settle;  // hold this beat back until the pipeline is empty
  } turn_req_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

  turn_req_t pending[$];
  point_t    rotated_due[$];
  int        total_items = 0;
  int        sent_count = 0;
  int        errors = 0;
  int        quiet = 0;
  int        idle_pct = 15;
  int        src_gap = 0;
  int        sink_gap = 0;
  bit        tail_run;

  vector_rotation_2d_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  assign tail_run = (sent_count >= total_items - TAIL_ITEMS);

  // Removes the CORDIC gain, rounds half up and clamps to 16 bits.
  function automatic logic signed [15:0] scale_clamp(longint v);
    longint r;
    r = (v * SCALE_K + (longint'(1) <<< 27)) >>> 28;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic point_t rotate_point(logic signed [15:0] px, logic signed [15:0] py,
                                          logic [15:0] ang);
    longint    rx, ry, rz, dx, dy;
    logic [15:0] turn;
    quadrant_t quad;
    point_t    res;
    turn = ang + 16'd8192;
    quad = quadrant_t'(turn[15:14]);
    rz = (longint'(turn[13:0]) - 8192) * 65536;
    case (quad)
      QUAD_0: begin
        rx = longint'(px);
        ry = longint'(py);
      end
      QUAD_90: begin
        rx = -longint'(py);
        ry = longint'(px);
      end
      QUAD_180: begin
        rx = -longint'(px);
        ry = -longint'(py);
      end
      default: begin
        rx = longint'(py);
        ry = -longint'(px);
      end
    endcase
    rx = rx * 256;
    ry = ry * 256;
    for (int i = 0; i < MICRO_STEPS; i++) begin
      dx = ry >>> i;
      dy = rx >>> i;
      if (rz >= 0) begin
        rx = rx - dx;
        ry = ry + dy;
        rz = rz - longint'(TURN_ARC[i]);
      end else begin
        rx = rx + dx;
        ry = ry - dy;
        rz = rz + longint'(TURN_ARC[i]);
      end
    end
    res.x = scale_clamp(rx);
    res.y = scale_clamp(ry);
    return res;
  endfunction

  task automatic add_point(logic [15:0] px, logic [15:0] py, logic [15:0] ang, bit settle);
    turn_req_t req;
    req.x = px;
    req.y = py;
    req.angle = ang;
    req.settle = settle;
    pending.push_back(req);
  endtask

  function automatic logic [15:0] edge_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'h0100;
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    logic [15:0] px, py, ang;
    // Unit vector through the quadrant boundaries and residual extremes.
    add_point(16'sd256, 16'sd0, 16'd0, 1'b0);
    add_point(16'sd256, 16'sd0, 16'd8192, 1'b0);
    add_point(16'sd256, 16'sd0, 16'd8191, 1'b0);
    add_point(16'sd256, 16'sd0, 16'd16384, 1'b0);
    add_point(16'sd256, 16'sd0, 16'd24576, 1'b0);
    add_point(16'sd256, 16'sd0, 16'h8000, 1'b0);
    add_point(16'sd256, 16'sd0, 16'h7FFF, 1'b0);
    add_point(16'sd256, 16'sd0, 16'hC000, 1'b0);
    add_point(16'sd256, 16'sd0, 16'hE000, 1'b0);
    add_point(16'sd256, 16'sd0, 16'hDFFF, 1'b0);
    add_point(16'sd0, 16'sd256, 16'hA000, 1'b0);
    // Coordinate extremes, several of which saturate.
    add_point(16'h7FFF, 16'h7FFF, 16'd8192, 1'b0);
    add_point(16'h8000, 16'h8000, 16'd8192, 1'b0);
    add_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
    add_point(16'h8000, 16'h7FFF, 16'd0, 1'b0);
    add_point(16'h7FFF, 16'h8000, 16'd16384, 1'b0);
    add_point(16'h8000, 16'h0000, 16'hC000, 1'b0);
    add_point(16'h7FFF, 16'h7FFF, 16'hE000, 1'b0);
    add_point(16'h0000, 16'h0000, 16'd12345, 1'b0);
    add_point(16'hFFFF, 16'h0001, 16'd4096, 1'b0);
    add_point(16'h0001, 16'hFFFF, 16'hF000, 1'b0);
    add_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      px = 16'($urandom());
      py = 16'($urandom());
      ang = 16'($urandom());
      case ($urandom_range(0, 5))
        1: begin
          px = 16'($urandom_range(0, 2047) - 1024);
          py = 16'($urandom_range(0, 2047) - 1024);
        end
        2: begin
          px = edge_coord();
          py = edge_coord();
        end
        3: ang = 16'($urandom_range(0, 3) * 16384 + 8192 + $urandom_range(0, 8) - 4);
        default: ;
      endcase
      // Let the pipeline run dry before the random part and once in the middle.
      add_point(px, py, ang, (n == 0) || (n == RANDOM_ITEMS / 2));
    end
    total_items = pending.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_items || rotated_due.size() != 0) @(negedge clk);
    repeat (STAGES + 20) @(posedge clk);
    if (errors == 0 && rotated_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Point driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        void'(pending.pop_front());
        sent_count++;
        if (sent_count % 50 == 0) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 12;
            default: idle_pct = 35;
          endcase
        end
        if (!tail_run && $urandom_range(0, 99) < idle_pct) src_gap = $urandom_range(1, 14);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].settle &&
                       (rotated_due.size() != 0 || (s_axis_tvalid && s_axis_tready)))) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {pending[0].angle, pending[0].y, pending[0].x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink with stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_gap = 0;
    end else if (sink_gap != 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!tail_run && $urandom_range(0, 299) < idle_pct) sink_gap = $urandom_range(1, 14);
    end
  end

  // Monitor: predicts on every accepted input beat, checks every output beat.
  always @(posedge clk) begin : monitor
    point_t want, got;
    if (rst) begin
      quiet = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        rotated_due.push_back(rotate_point(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                           s_axis_tdata[47:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[15:0];
        got.y = m_axis_tdata[31:16];
        if (rotated_due.size() == 0) begin
          $display("%0t: unexpected beat, x_out %0d y_out %0d", $time, got.x, got.y);
          errors++;
        end else begin
          want = rotated_due.pop_front();
          if (got.x !== want.x) begin
            $display("%0t: x_out expected %0d, got %0d", $time, want.x, got.x);
            errors++;
          end
          if (got.y !== want.y) begin
            $display("%0t: y_out expected %0d, got %0d", $time, want.y, got.y);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
